@@ sv/bcpt_pkg.sv @@
// Package for the commutation period tracker.
// Holds the beat types, request codes, register indexes and step helper.
// No dependencies.
package bcpt_pkg;

   localparam int unsigned STEPS      = 6;
   localparam int unsigned STEP_W     = $clog2(STEPS);
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned SUM_W      = 19;
   localparam int unsigned DELAY_W    = 15;
   localparam int unsigned FAIL_W     = 8;
   localparam int unsigned CSR_IDX_W  = 1;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [15:0] SETTLE_RESET = 16'd100;
   localparam logic [7:0]  LIMIT_RESET  = 8'd10;

   typedef logic [STEP_W-1:0] step_type;

   typedef enum logic [1:0] {
      REQ_ZERO_CROSS = 2'd0,
      REQ_TIMEOUT    = 2'd1,
      REQ_ENTER      = 2'd2
   } req_code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETTLE_COUNT = 1'd0,
      CSR_FAIL_LIMIT   = 1'd1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [TIME_W-1:0] elapsed_time;
   } req_beat_type;

   typedef struct packed {
      logic               accepted;
      logic [DELAY_W-1:0] advance_delay;
      logic               stalled;
      logic [SUM_W-1:0]   filtered_period;
      logic [FAIL_W-1:0]  fail_level;
      logic [2:0]         step_index;
   } rsp_beat_type;

   // Control from the execute logic to the period window store
   typedef struct packed {
      logic              rd_en;
      step_type          rd_step;
      logic              wr_en;
      step_type          wr_addr;
      logic [TIME_W-1:0] wr_data;
      logic              clear;
   } win_ctl_type;

   function automatic step_type step_next(input step_type s);
      step_type r;
      if (s == step_type'(STEPS - 1)) begin
         r = '0;
      end else begin
         r = s + step_type'(1);
      end
      return r;
   endfunction

endpackage

@@ sv/bcpt_window_mem.sv @@
// Six-slot period window store: synchronous array, two registered read ports.
// Per-slot valid flags give zero for slots not written since reset or enter.
// Depends on bcpt_pkg.
module bcpt_window_mem (
   input  logic                                clock,
   input  logic                                reset,
   input  bcpt_pkg::win_ctl_type               ctl,
   input  bcpt_pkg::step_type                  ex_slot,
   output logic [bcpt_pkg::TIME_W-1:0]         slot_data
);
   import bcpt_pkg::*;

   logic [TIME_W-1:0] mem [STEPS];
   logic [STEPS-1:0]  valid_ff;
   logic [STEPS-1:0]  valid_in;
   logic [TIME_W-1:0] q0_ff, q1_ff;
   step_type          a0_ff, a1_ff;
   step_type          a0, a1;

   // Both candidate slots: the next step, and the one after in case the
   // item ahead advances the step at the same edge.
   assign a0 = step_next(ctl.rd_step);
   assign a1 = step_next(a0);

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= ctl.wr_data;
      end
      if (ctl.rd_en) begin
         q0_ff <= mem[a0];
         q1_ff <= mem[a1];
         a0_ff <= a0;
         a1_ff <= a1;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear) begin
         valid_in = '0;
      end else if (ctl.wr_en) begin
         valid_in[ctl.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      slot_data = '0;
      if (valid_ff[ex_slot]) begin
         slot_data = (ex_slot == a0_ff) ? q0_ff : q1_ff;
      end
      if (ex_slot != a0_ff && ex_slot != a1_ff) begin
         slot_data = '0;
      end
   end

endmodule

@@ sv/bldc_commutation_period_tracker.sv @@
// Commutation period tracker for a sensorless BLDC drive (closed loop).
// Request to response: through the execute register, then the output register.
// Throughput: 1 beat per cycle while rsp_ready does not hold back the output;
//   window slot read registered at accept, before execute reads and rewrites it.
// Reset (synchronous, active high): all tracking state zero, window empty,
//   settle_count 100, fail_limit 10, pipeline empty. No clearing pass.
module bldc_commutation_period_tracker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  bcpt_pkg::req_beat_type            req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output bcpt_pkg::rsp_beat_type            rsp_data,
   input  logic                              csr_wr_en,
   input  logic [bcpt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bcpt_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bcpt_pkg::*;

   // ---------------- configuration ----------------
   logic [15:0] settle_ff;
   logic [7:0]  limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
         limit_ff  <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_SETTLE_COUNT: settle_ff <= csr_wdata;
            CSR_FAIL_LIMIT:   limit_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // ---------------- handshake / pipeline control ----------------
   logic         ex_valid_ff;
   req_beat_type ex_beat_ff;
   logic         rsp_valid_ff;
   rsp_beat_type rsp_beat_ff;
   logic         ex_move;
   logic         accept;

   // Execute retires when the output register is empty or being drained
   assign ex_move   = ex_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !ex_valid_ff || ex_move;
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else if (accept) begin
         ex_valid_ff <= 1'b1;
      end else if (ex_move) begin
         ex_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         ex_beat_ff <= req_data;
      end
   end

   // ---------------- tracking state ----------------
   step_type          step_ff,  step_in;
   logic [SUM_W-1:0]  wsum_ff,  wsum_in;
   logic [SUM_W-1:0]  filt_ff,  filt_in;
   logic [15:0]       count_ff, count_in;
   logic [FAIL_W-1:0] fail_ff,  fail_in;
   logic              stall_ff, stall_in;

   // ---------------- period window store ----------------
   win_ctl_type       win_ctl;
   step_type          ex_slot;
   logic [TIME_W-1:0] old_period;

   bcpt_window_mem u_window (
      .clock     (clock),
      .reset     (reset),
      .ctl       (win_ctl),
      .ex_slot   (ex_slot),
      .slot_data (old_period)
   );

   // ---------------- execute ----------------
   logic [TIME_W-1:0] e;
   logic [16:0]       e_inc;
   logic [20:0]       glitch_lhs;
   logic              settled;
   logic              glitch;
   logic              zc_take;
   logic [SUM_W-1:0]  wsum_new;
   logic [21:0]       filt_x7;
   logic [21:0]       filt_acc;
   logic [SUM_W-1:0]  filt_new;
   logic [15:0]       count_new;
   logic [20:0]       e_x24;
   logic [21:0]       filt_x5;
   logic              in_window;

   assign e       = ex_beat_ff.elapsed_time;
   assign ex_slot = step_next(step_ff);
   assign settled = count_ff > settle_ff;

   // e < floor(f/12)  <=>  12*(e+1) <= f
   assign e_inc      = {1'b0, e} + 17'd1;
   assign glitch_lhs = 21'({e_inc, 3'b000}) + 21'({e_inc, 2'b00});
   assign glitch     = settled && (glitch_lhs <= 21'(filt_ff));

   // 7f + window sum stays below 2^22
   assign wsum_new  = wsum_ff - SUM_W'(old_period) + SUM_W'(e);
   assign filt_x7   = 22'({filt_ff, 3'b000}) - 22'(filt_ff);
   assign filt_acc  = filt_x7 + 22'(wsum_new);
   assign filt_new  = filt_acc[21:3];
   assign count_new = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;

   // Period must lie strictly between f/8 and 5f/24 of the updated filtered period
   assign e_x24     = 21'({e, 4'b0000}) + 21'({e, 3'b000});
   assign filt_x5   = 22'({filt_new, 2'b00}) + 22'(filt_new);
   assign in_window = (e > filt_new[18:3]) && (22'(e_x24) < filt_x5);

   always_comb begin
      step_in  = step_ff;
      wsum_in  = wsum_ff;
      filt_in  = filt_ff;
      count_in = count_ff;
      fail_in  = fail_ff;
      stall_in = stall_ff;
      zc_take  = 1'b0;
      case (req_code_type'(ex_beat_ff.req_type))
         REQ_ZERO_CROSS: begin
            if (!stall_ff && !glitch) begin
               zc_take  = 1'b1;
               step_in  = ex_slot;
               wsum_in  = wsum_new;
               filt_in  = filt_new;
               count_in = count_new;
               if (count_new > settle_ff) begin
                  if (in_window) begin
                     if (fail_ff != '0) begin
                        fail_in = fail_ff - FAIL_W'(1);
                     end
                  end else begin
                     if (fail_ff > limit_ff) begin
                        stall_in = 1'b1;
                     end
                     if (fail_ff != '1) begin
                        fail_in = fail_ff + FAIL_W'(1);
                     end
                  end
               end
            end
         end
         REQ_TIMEOUT: begin
            if (settled) begin
               stall_in = 1'b1;
            end
         end
         REQ_ENTER: begin
            wsum_in  = '0;
            filt_in  = SUM_W'(e);
            count_in = '0;
            fail_in  = '0;
            stall_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_comb begin
      win_ctl.rd_en   = accept;
      win_ctl.rd_step = step_ff;
      win_ctl.wr_en   = ex_move && zc_take;
      win_ctl.wr_addr = ex_slot;
      win_ctl.wr_data = e;
      win_ctl.clear   = ex_move && (req_code_type'(ex_beat_ff.req_type) == REQ_ENTER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         wsum_ff  <= '0;
         filt_ff  <= '0;
         count_ff <= '0;
         fail_ff  <= '0;
         stall_ff <= 1'b0;
      end else if (ex_move) begin
         step_ff  <= step_in;
         wsum_ff  <= wsum_in;
         filt_ff  <= filt_in;
         count_ff <= count_in;
         fail_ff  <= fail_in;
         stall_ff <= stall_in;
      end
   end

   // ---------------- output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ex_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ex_move) begin
         rsp_beat_ff.accepted        <= zc_take;
         // delay comes from the filtered period before this beat's update
         rsp_beat_ff.advance_delay   <= zc_take ? filt_ff[18:4] : '0;
         rsp_beat_ff.stalled         <= stall_in;
         rsp_beat_ff.filtered_period <= filt_in;
         rsp_beat_ff.fail_level      <= fail_in;
         rsp_beat_ff.step_index      <= 3'(step_in);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_beat_ff;

endmodule

@@ sv/bcpt_checker.sv @@
// Port-level checks for the commutation period tracker, bound to the top level.
// Depends on bcpt_pkg and bldc_commutation_period_tracker.
module bcpt_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input bcpt_pkg::req_beat_type            req_data,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input bcpt_pkg::rsp_beat_type            rsp_data
);
   import bcpt_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("request beat dropped or changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.step_index < 3'(STEPS))
      else $error("step index out of range");

   a_delay_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.accepted |-> rsp_data.advance_delay == '0)
      else $error("advance delay on a rejected beat");

endmodule

bind bldc_commutation_period_tracker bcpt_checker u_bcpt_checker (.*);
